### sv/srg_pkg.sv
// ----------------------------------------------------------------------------
// srg_pkg - shared types and constants of the sorted run generator
// Field widths, command and register codes, and the letter filter.
// ----------------------------------------------------------------------------
package srg_pkg;

	localparam int CHAR_W       = 8;
	localparam int RUN_LENGTH_W = 7;
	localparam int FILE_COUNT_W = 5;
	localparam int FILE_W       = 4;
	localparam int RUN_CNT_W    = 16;
	localparam int CFG_DATA_W   = 7;

	typedef logic [CHAR_W-1:0]       char_t;
	typedef logic [FILE_W-1:0]       file_t;
	typedef logic [RUN_CNT_W-1:0]    run_cnt_t;
	typedef logic [RUN_LENGTH_W-1:0] run_len_t;
	typedef logic [FILE_COUNT_W-1:0] file_cnt_t;

	// Input command codes
	localparam logic CMD_CHAR  = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	// Configuration register indexes
	localparam logic CFG_RUN_LENGTH = 1'b0;
	localparam logic CFG_FILE_COUNT = 1'b1;

	localparam run_len_t  RUN_LENGTH_RST = 7'd4;
	localparam file_cnt_t FILE_COUNT_RST = 5'd3;
	localparam run_cnt_t  RUN_CNT_MAX    = 16'hFFFF;

	localparam char_t UPPER_A = 8'h41;
	localparam char_t UPPER_Z = 8'h5A;
	localparam char_t LOWER_A = 8'h61;
	localparam char_t LOWER_Z = 8'h7A;

	function automatic logic is_letter(input char_t c);
		return ((c >= UPPER_A) && (c <= UPPER_Z)) || ((c >= LOWER_A) && (c <= LOWER_Z));
	endfunction

endpackage

### sv/sorted_run_generator_unit.sv
// ----------------------------------------------------------------------------
// sorted_run_generator_unit - run formation for an external sort
// Filters letters from a byte stream and emits ascending runs with file tags.
// ----------------------------------------------------------------------------
// Timing: a transfer is taken when start is high and busy is low. A byte that
// is not a letter, and an end-of-input command with nothing held, finish in
// the cycle they are taken. A letter is placed by insertion into the sorted
// buffer through one shared compare-and-shift step, walking past each held
// letter above it before it is written in place; a letter is inserted only
// while fewer than RUN_MAX are held. When the letter completes a run, or when
// end of input finds letters held, the run is streamed out from the buffer's
// read port at one letter a cycle; each letter is registered between its
// read and the result ports. Each result is shown for exactly one cycle with
// result_valid high; there is no back-pressure, so the receiver must take
// every letter as it appears. Configuration may be written only while busy
// is low.
// ----------------------------------------------------------------------------
module sorted_run_generator_unit import srg_pkg::*; #(
	parameter int RUN_MAX   = 16,
	parameter int FILES_MAX = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_write,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// command side
	input  logic                  start,
	output logic                  busy,
	input  logic                  cmd,
	input  char_t                 char_code,
	// result side
	output logic                  result_valid,
	output char_t                 letter,
	output file_t                 file_index,
	output logic                  append_mode,
	output logic                  run_last
);

	localparam int IDX_W = (RUN_MAX > 1) ? $clog2(RUN_MAX) : 1;
	localparam int CNT_W = $clog2(RUN_MAX + 1);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_INSERT = 2'd1;
	localparam logic [1:0] S_EMIT   = 2'd2;

	logic [1:0]       state_q;
	run_len_t         run_length_q;
	file_cnt_t        file_count_q;
	logic [CNT_W-1:0] held_q;
	run_cnt_t         run_cnt_q;
	file_t            cycle_q;
	logic [IDX_W-1:0] emit_idx_q;
	file_t            run_file_q;
	logic             run_app_q;

	logic             valid_q;
	char_t            letter_q;
	file_t            file_q;
	logic             app_q;
	logic             last_q;

	// buffer interface
	logic             ins_start;
	logic             ins_done;
	char_t            rd_data;

	// decoded controls
	logic             accept;
	logic             take_letter;
	logic             flush_go;
	logic             emit_go;
	logic             emit_last;
	logic [CNT_W-1:0] held_inc;
	run_len_t         eff_len;
	file_cnt_t        eff_files;
	file_t            span;
	file_t            cyc_fix;
	file_t            tag_file;
	logic             tag_app;
	file_t            cyc_next;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// clamp the registers to their legal ranges
	always_comb begin
		eff_len = run_length_q;
		if (run_length_q == '0) begin
			eff_len = run_len_t'(1);
		end else if (run_length_q > run_len_t'(RUN_MAX)) begin
			eff_len = run_len_t'(RUN_MAX);
		end
		eff_files = file_count_q;
		if (file_count_q == '0) begin
			eff_files = file_cnt_t'(1);
		end else if (file_count_q > file_cnt_t'(FILES_MAX)) begin
			eff_files = file_cnt_t'(FILES_MAX);
		end
	end

	// file choice: first runs overwrite their own file, later ones append
	// round-robin; a stale cycle position past the span restarts at file 1
	always_comb begin
		span     = file_t'(eff_files - file_cnt_t'(1));
		cyc_fix  = ((cycle_q == '0) || (cycle_q > span)) ? file_t'(1) : cycle_q;
		cyc_next = (cyc_fix >= span) ? file_t'(1) : cyc_fix + file_t'(1);
		if (run_cnt_q < RUN_CNT_W'(eff_files)) begin
			tag_file = run_cnt_q[FILE_W-1:0];
			tag_app  = 1'b0;
		end else begin
			tag_file = (span <= file_t'(1)) ? file_t'(1) : cyc_fix;
			tag_app  = 1'b1;
		end
	end

	assign held_inc    = held_q + CNT_W'(1);
	assign take_letter = accept && (cmd == CMD_CHAR) && is_letter(char_code);
	assign flush_go    = accept && (cmd == CMD_FLUSH);
	// a letter arriving on a full buffer is dropped but still closes the run
	assign ins_start   = take_letter && (held_q < CNT_W'(RUN_MAX));

	always_comb begin
		emit_go = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				emit_go = (flush_go && (held_q != '0))
					|| (take_letter && !ins_start
					&& (run_len_t'(held_q) >= eff_len));
			end
			S_INSERT: begin
				emit_go = ins_done && (run_len_t'(held_inc) >= eff_len);
			end
			S_EMIT: begin
				emit_go = 1'b0;
			end
			default: begin
				emit_go = 1'b0;
			end
		endcase
	end

	assign emit_last = (state_q == S_EMIT) && ((CNT_W'(emit_idx_q) + CNT_W'(1)) == held_q);

	srg_run_buffer #(
		.RUN_MAX (RUN_MAX)
	) u_buffer (
		.clk       (clk),
		.arst_n    (arst_n),
		.ins_start (ins_start),
		.ins_pos   (held_q[IDX_W-1:0]),
		.ins_value (char_code),
		.ins_done  (ins_done),
		.rd_idx    (emit_idx_q),
		.rd_data   (rd_data)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_length_q <= RUN_LENGTH_RST;
			file_count_q <= FILE_COUNT_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_RUN_LENGTH: run_length_q <= cfg_data[RUN_LENGTH_W-1:0];
				CFG_FILE_COUNT: run_length_q <= run_length_q;
				default:        run_length_q <= run_length_q;
			endcase
			if (cfg_index == CFG_FILE_COUNT) begin
				file_count_q <= cfg_data[FILE_COUNT_W-1:0];
			end
		end
	end

	// sequencer: idle -> insert walk -> (optional) run emission, or idle -> emission
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			held_q     <= '0;
			run_cnt_q  <= run_cnt_t'(1);
			cycle_q    <= file_t'(1);
			emit_idx_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (ins_start) begin
						state_q <= S_INSERT;
					end else if (emit_go) begin
						state_q <= S_EMIT;
					end
				end
				S_INSERT: begin
					if (ins_done) begin
						held_q  <= held_inc;
						state_q <= emit_go ? S_EMIT : S_IDLE;
					end
				end
				S_EMIT: begin
					emit_idx_q <= emit_idx_q + IDX_W'(1);
					if (emit_last) begin
						held_q  <= '0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// advance run numbering at run start; end of input restarts it
			if (flush_go) begin
				run_cnt_q <= run_cnt_t'(1);
				cycle_q   <= file_t'(1);
			end else if (emit_go) begin
				cycle_q <= cyc_next;
				if (run_cnt_q != RUN_CNT_MAX) begin
					run_cnt_q <= run_cnt_q + run_cnt_t'(1);
				end
			end
			if (emit_go) begin
				emit_idx_q <= '0;
			end
		end
	end

	// hold the run's tag for the whole emission
	always_ff @(posedge clk) begin
		if (emit_go) begin
			run_file_q <= tag_file;
			run_app_q  <= tag_app;
		end
	end

	// result register: one letter per cycle, strobed for a single cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= (state_q == S_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT) begin
			letter_q <= rd_data;
			file_q   <= run_file_q;
			app_q    <= run_app_q;
			last_q   <= emit_last;
		end
	end

	assign result_valid = valid_q;
	assign letter       = letter_q;
	assign file_index   = file_q;
	assign append_mode  = app_q;
	assign run_last     = last_q;

endmodule

### sv/srg_run_buffer.sv
// ----------------------------------------------------------------------------
// srg_run_buffer - sorted letter buffer with insertion walk
// Keeps held letters in ascending order; one compare-and-shift step a cycle.
// ----------------------------------------------------------------------------
module srg_run_buffer import srg_pkg::*; #(
	parameter int RUN_MAX = 16,
	localparam int IDX_W  = (RUN_MAX > 1) ? $clog2(RUN_MAX) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             ins_start,
	input  logic [IDX_W-1:0] ins_pos,
	input  char_t            ins_value,
	output logic             ins_done,
	input  logic [IDX_W-1:0] rd_idx,
	output char_t            rd_data
);

	char_t            buf_q [RUN_MAX];
	logic             active_q;
	logic [IDX_W-1:0] walk_q;
	char_t            val_q;

	logic [IDX_W-1:0] rd_addr;
	logic             shift;

	// single read port: walk neighbor while inserting, else the emit index
	assign rd_addr  = active_q ? (walk_q - IDX_W'(1)) : rd_idx;
	assign rd_data  = buf_q[rd_addr];
	assign shift    = active_q && (walk_q != '0) && (rd_data > val_q);
	assign ins_done = active_q && !shift;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (ins_start) begin
			active_q <= 1'b1;
		end else if (ins_done) begin
			active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ins_start) begin
			walk_q <= ins_pos;
			val_q  <= ins_value;
		end else if (shift) begin
			buf_q[walk_q] <= rd_data;
			walk_q        <= walk_q - IDX_W'(1);
		end else if (ins_done) begin
			buf_q[walk_q] <= val_q;
		end
	end

endmodule

### sv/srg_checker.sv
// ----------------------------------------------------------------------------
// srg_checker - port-level checks of the sorted run generator
// Watches result strobes for prior busy, run continuity, order and tag rules.
// ----------------------------------------------------------------------------
module srg_checker import srg_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  busy,
	input logic  result_valid,
	input char_t letter,
	input file_t file_index,
	input logic  append_mode,
	input logic  run_last
);

	// a result only follows a cycle of work
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result without preceding busy cycle");

	// a run streams without gaps until its last letter
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !run_last) |=> result_valid)
		else $error("gap inside a run");

	// letters never fall within a run
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !run_last) |=> (letter >= $past(letter)))
		else $error("run not in ascending order");

	// file tag holds over a run
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !run_last) |=>
			((file_index == $past(file_index)) && (append_mode == $past(append_mode))))
		else $error("file tag changed within a run");

	// file zero is never a target
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (file_index != '0))
		else $error("run tagged with file zero");

endmodule

bind sorted_run_generator_unit srg_checker u_srg_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.busy         (busy),
	.result_valid (result_valid),
	.letter       (letter),
	.file_index   (file_index),
	.append_mode  (append_mode),
	.run_last     (run_last)
);
